>>> rtl/rotation_matrix_to_quaternion_top_macros.svh
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define RMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RMQ_ASSERT(label, prop, msg)
`define RMQ_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    localparam int SUM_W     = DATA_WIDTH + 3;
    localparam int BEST_W    = SUM_W - 1;
    localparam int RAD_RAW   = BEST_W + FRAC_BITS;
    localparam int RAD_W     = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int BIG_W     = ROOT_W - 1;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int NUM_W     = DATA_WIDTH + 1;
    localparam int DVD_W     = NUM_W + FRAC_BITS;
    localparam int DV_REM_W  = ROOT_W + 2;
    localparam int IN_W      = 9 * DATA_WIDTH;
    localparam int IN_BYTES  = (IN_W + 7) / 8;
    localparam int OUT_W     = 4 * DATA_WIDTH;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] BR_SCALAR = 2'd0;
    localparam logic [1:0] BR_I      = 2'd1;
    localparam logic [1:0] BR_J      = 2'd2;
    localparam logic [1:0] BR_K      = 2'd3;

    // num0..num2: numerators of the three derived components, ascending index
    typedef struct packed {
        logic [1:0]              br;
        logic                    inv;
        logic [BEST_W-1:0]       best;
        logic signed [NUM_W-1:0] num0;
        logic signed [NUM_W-1:0] num1;
        logic signed [NUM_W-1:0] num2;
    } rmq_item_t;

endpackage

>>> rtl/rmq_fifo.sv
module rmq_fifo
    import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rmq_item_t push_item,
    output logic      full,
    input  logic      pop,
    output rmq_item_t pop_item,
    output logic      empty
);

`include "rotation_matrix_to_quaternion_top_macros.svh"

    rmq_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `RMQ_ASSERT(a_no_overflow, (push |-> (!full || pop)), "fifo push while full")
    `RMQ_ASSERT(a_no_underflow, (pop |-> !empty), "fifo pop while empty")
    `RMQ_ASSERT_NEXT(a_count_track, (push && !pop), (count_reg == $past(count_reg) + 1'b1), "fifo count lost a push")

endmodule

>>> rtl/rmq_front.sv
module rmq_front
    import rmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_W-1:0]       in_data,
    output logic                  push,
    output rmq_item_t             push_item,
    input  logic                  fifo_full
);

    logic signed [DATA_WIDTH-1:0] nx, ny, nz, ex, ey, ez, dx, dy, dz;
    logic signed [SUM_W-1:0]      a, b, c, one, s0, s1, s2, s3, best;
    logic signed [NUM_W-1:0]      d_i, d_j, d_k, p_ij, p_ik, p_jk;
    logic [1:0]                   br;
    rmq_item_t                    item_next;
    rmq_item_t                    item_reg;
    logic                         vld_reg;

    assign nx = in_data[0*DATA_WIDTH +: DATA_WIDTH];
    assign ny = in_data[1*DATA_WIDTH +: DATA_WIDTH];
    assign nz = in_data[2*DATA_WIDTH +: DATA_WIDTH];
    assign ex = in_data[3*DATA_WIDTH +: DATA_WIDTH];
    assign ey = in_data[4*DATA_WIDTH +: DATA_WIDTH];
    assign ez = in_data[5*DATA_WIDTH +: DATA_WIDTH];
    assign dx = in_data[6*DATA_WIDTH +: DATA_WIDTH];
    assign dy = in_data[7*DATA_WIDTH +: DATA_WIDTH];
    assign dz = in_data[8*DATA_WIDTH +: DATA_WIDTH];

    assign a   = SUM_W'(nx);
    assign b   = SUM_W'(ey);
    assign c   = SUM_W'(dz);
    assign one = SUM_W'(1) <<< FRAC_BITS;
    assign s0  = one + a + b + c;
    assign s1  = one + a - b - c;
    assign s2  = one - a + b - c;
    assign s3  = one - a - b + c;

    assign d_i  = NUM_W'(dy) - NUM_W'(ez);
    assign d_j  = NUM_W'(nz) - NUM_W'(dx);
    assign d_k  = NUM_W'(ex) - NUM_W'(ny);
    assign p_ij = NUM_W'(ny) + NUM_W'(ex);
    assign p_ik = NUM_W'(nz) + NUM_W'(dx);
    assign p_jk = NUM_W'(ez) + NUM_W'(dy);

    always_comb
    begin
        best = s0;
        br   = BR_SCALAR;
        if (s1 > best)
        begin
            best = s1;
            br   = BR_I;
        end
        if (s2 > best)
        begin
            best = s2;
            br   = BR_J;
        end
        if (s3 > best)
        begin
            best = s3;
            br   = BR_K;
        end
        item_next.inv  = (best <= 0);
        item_next.br   = item_next.inv ? BR_SCALAR : br;
        item_next.best = best[BEST_W-1:0];
        case (br)
            BR_SCALAR:
            begin
                item_next.num0 = d_i;
                item_next.num1 = d_j;
                item_next.num2 = d_k;
            end
            BR_I:
            begin
                item_next.num0 = d_i;
                item_next.num1 = p_ij;
                item_next.num2 = p_ik;
            end
            BR_J:
            begin
                item_next.num0 = d_j;
                item_next.num1 = p_ij;
                item_next.num2 = p_jk;
            end
            default:
            begin
                item_next.num0 = d_k;
                item_next.num1 = p_ik;
                item_next.num2 = p_jk;
            end
        endcase
    end

    assign push      = vld_reg && !fifo_full;
    assign in_ready  = !vld_reg || !fifo_full;
    assign push_item = item_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

endmodule

>>> rtl/rmq_back.sv
module rmq_back
    import rmq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fifo_empty,
    input  rmq_item_t              fifo_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       out_data,
    output logic [2:0]             out_user
);

    localparam logic [DVD_W-1:0] POS_MAX = DVD_W'({(DATA_WIDTH-1){1'b1}});
    localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (DATA_WIDTH-1);

    typedef struct packed {
        logic [DVD_W-1:0]    dvd;
        logic [DV_REM_W-1:0] rem;
        logic [DVD_W-1:0]    quo;
        logic                neg;
    } lane_t;

    logic adv;

    logic                sq_vld_reg  [0:ROOT_W];
    rmq_item_t           sq_item_reg [0:ROOT_W];
    logic [RAD_W-1:0]    sq_rad_reg  [0:ROOT_W];
    logic [SQ_REM_W-1:0] sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   sq_root_reg [0:ROOT_W];

    logic                dv_vld_reg  [0:DVD_W];
    rmq_item_t           dv_item_reg [0:DVD_W];
    logic [BIG_W-1:0]    dv_big_reg  [0:DVD_W];
    logic [DEN_W-1:0]    dv_den_reg  [0:DVD_W];
    lane_t               dv_lane_reg [0:DVD_W][3];

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic [2:0]            out_user_reg;
    logic [OUT_W-1:0]      out_data_next;

    function automatic lane_t lane_load(input logic signed [NUM_W-1:0] num);
        lane_t            l;
        logic [NUM_W-1:0] mag;
        mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        l.neg = num[NUM_W-1];
        l.dvd = {mag, {FRAC_BITS{1'b0}}};
        l.rem = '0;
        l.quo = '0;
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input logic [DEN_W-1:0] den);
        lane_t               r;
        logic [DV_REM_W-1:0] sh;
        sh    = {l.rem[DV_REM_W-2:0], l.dvd[DVD_W-1]};
        r     = l;
        r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
        if (sh >= DV_REM_W'(den))
        begin
            r.rem = sh - DV_REM_W'(den);
            r.quo = {l.quo[DVD_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh;
            r.quo = {l.quo[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] sat_q(input logic neg, input logic [DVD_W-1:0] q);
        logic [DATA_WIDTH-1:0] r;
        if (neg)
            r = (q >= NEG_LIM) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                               : DATA_WIDTH'(~q + 1'b1);
        else
            r = (q > POS_MAX) ? POS_MAX[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
        return r;
    endfunction

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !fifo_empty;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_item_reg[0] <= fifo_item;
            sq_rad_reg[0]  <= RAD_W'({fifo_item.best, {FRAC_BITS{1'b0}}});
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    generate
        for (genvar k = 0; k < ROOT_W; k++)
        begin : g_sqrt
            logic [SQ_REM_W-1:0] sh;
            logic [SQ_REM_W-1:0] trial;
            assign sh    = {sq_rem_reg[k][SQ_REM_W-3:0], sq_rad_reg[k][RAD_W-1 -: 2]};
            assign trial = SQ_REM_W'({sq_root_reg[k], 2'b01});
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_item_reg[k+1] <= sq_item_reg[k];
                    sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                    if (sh >= trial)
                    begin
                        sq_rem_reg[k+1]  <= sh - trial;
                        sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg[k+1]  <= sh;
                        sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        for (genvar k = 0; k < DVD_W; k++)
        begin : g_div
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_item_reg[k+1] <= dv_item_reg[k];
                    dv_big_reg[k+1]  <= dv_big_reg[k];
                    dv_den_reg[k+1]  <= dv_den_reg[k];
                    for (int n = 0; n < 3; n++)
                        dv_lane_reg[k+1][n] <= lane_step(dv_lane_reg[k][n], dv_den_reg[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0]    <= sq_item_reg[ROOT_W];
            dv_big_reg[0]     <= sq_root_reg[ROOT_W][ROOT_W-1:1];
            dv_den_reg[0]     <= {sq_root_reg[ROOT_W][ROOT_W-1:1], 2'b00};
            dv_lane_reg[0][0] <= lane_load(sq_item_reg[ROOT_W].num0);
            dv_lane_reg[0][1] <= lane_load(sq_item_reg[ROOT_W].num1);
            dv_lane_reg[0][2] <= lane_load(sq_item_reg[ROOT_W].num2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= DVD_W; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= !fifo_empty;
            for (int k = 0; k < ROOT_W; k++)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            dv_vld_reg[0] <= sq_vld_reg[ROOT_W];
            for (int k = 0; k < DVD_W; k++)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
        end
    end

    always_comb
    begin
        logic [DATA_WIDTH-1:0] big_s, l0, l1, l2;
        big_s = sat_q(1'b0, DVD_W'(dv_big_reg[DVD_W]));
        l0    = sat_q(dv_lane_reg[DVD_W][0].neg, dv_lane_reg[DVD_W][0].quo);
        l1    = sat_q(dv_lane_reg[DVD_W][1].neg, dv_lane_reg[DVD_W][1].quo);
        l2    = sat_q(dv_lane_reg[DVD_W][2].neg, dv_lane_reg[DVD_W][2].quo);
        case (dv_item_reg[DVD_W].br)
            BR_SCALAR: out_data_next = {l2, l1, l0, big_s};
            BR_I:      out_data_next = {l2, l1, big_s, l0};
            BR_J:      out_data_next = {l2, big_s, l1, l0};
            default:   out_data_next = {big_s, l2, l1, l0};
        endcase
        if (dv_item_reg[DVD_W].inv)
            out_data_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {dv_item_reg[DVD_W].inv, dv_item_reg[DVD_W].br};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_vld_reg[DVD_W];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

>>> rtl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion (Shepperd). Takes one 3x3 matrix per cycle in
// Q2.14 while the output is not stalled and returns one quaternion per request,
// saturated to Q2.14, plus the branch chosen and an invalid flag. Fully
// pipelined: sustained rate is one request per clock when the output is not
// stalled. Stages: input register, 16-stage square root, 31-stage divider
// with three lanes, output register. A two-entry queue sits between front and back.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // north_x, north_y, north_z, east_x, east_y, east_z, down_x, down_y, down_z
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // quat_scalar, quat_i, quat_j, quat_k
    output logic [OUT_BYTES*8-1:0] m_tdata,
    // branch_taken[1:0], invalid_input
    output logic [2:0]             m_tuser
);

    logic      push, fifo_full, fifo_empty, pop;
    rmq_item_t push_item, pop_item;
    logic [OUT_W-1:0] out_data;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IN_W-1:0]),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    rmq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    rmq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_item  (pop_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_user   (m_tuser)
    );

    assign m_tdata = (OUT_BYTES*8)'(out_data);

endmodule
